// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SCFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define SCFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define SCFE_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/scfe_pkg.sv =====
// ----------------------------------------------------------------------------
// scfe_pkg
// Types and codes shared by the frame evictor cells and the top level.
// ----------------------------------------------------------------------------
package scfe_pkg;

    localparam logic [2:0] MODE_ALLOC  = 3'd0;
    localparam logic [2:0] MODE_FREE   = 3'd1;
    localparam logic [2:0] MODE_ACCESS = 3'd2;
    localparam logic [2:0] MODE_DIRTY  = 3'd3;
    localparam logic [2:0] MODE_PIN    = 3'd4;
    localparam logic [2:0] MODE_UNPIN  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd1;
    localparam logic [1:0] ST_ALL_PINNED = 2'd2;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_MARK,
        CMD_APPEND,
        CMD_CLEAR_ACC,
        CMD_REMOVE,
        CMD_EVICT
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] mode;
    } t_cell_ctl;

    typedef struct packed {
        logic        acc;
        logic        dirty;
        logic        pin;
        logic        swap;
        logic [7:0]  owner;
        logic [19:0] vpage;
    } t_slot;

endpackage

// ===== src/scfe_cell.sv =====
// ----------------------------------------------------------------------------
// scfe_cell
// One position of the age order: a frame number and its mapping and flags.
// ----------------------------------------------------------------------------
module scfe_cell
    import scfe_pkg::*;
#(
    parameter int ID_W = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic [ID_W-1:0] i_match_id,
    input  logic [ID_W-1:0] i_new_id,
    input  t_slot           i_new_slot,
    input  logic            i_sel,
    input  logic            i_after,
    input  logic            i_prev_valid,
    input  logic            i_next_valid,
    input  logic [ID_W-1:0] i_next_id,
    input  t_slot           i_next_slot,
    output logic            o_valid,
    output logic [ID_W-1:0] o_id,
    output t_slot           o_slot
);

    logic            r_valid, n_valid;
    logic [ID_W-1:0] r_id, n_id;
    t_slot           r_slot, n_slot;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_slot  = r_slot;
        case (i_ctl.cmd)
            CMD_MARK: begin
                if (r_valid && (r_id == i_match_id)) begin
                    case (i_ctl.mode)
                        MODE_ACCESS: n_slot.acc   = 1'b1;
                        MODE_DIRTY:  n_slot.dirty = 1'b1;
                        MODE_PIN:    n_slot.pin   = 1'b1;
                        MODE_UNPIN:  n_slot.pin   = 1'b0;
                        default:     n_slot       = r_slot;
                    endcase
                end
            end
            CMD_APPEND: begin
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_id    = i_new_id;
                    n_slot  = i_new_slot;
                end
            end
            CMD_CLEAR_ACC: begin
                if (i_sel) begin
                    n_slot.acc = 1'b0;
                end
            end
            CMD_REMOVE: begin
                if (i_after) begin
                    n_valid = i_next_valid;
                    n_id    = i_next_id;
                    n_slot  = i_next_slot;
                end
            end
            CMD_EVICT: begin
                // The victim leaves its place and the new mapping lands at the tail.
                if (i_after && r_valid) begin
                    if (i_next_valid) begin
                        n_id   = i_next_id;
                        n_slot = i_next_slot;
                    end else begin
                        n_id   = i_new_id;
                        n_slot = i_new_slot;
                    end
                end
            end
            default: n_valid = r_valid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_id   <= n_id;
        r_slot <= n_slot;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_slot  = r_slot;

endmodule

// ===== src/second_chance_frame_evictor_core.sv =====
// ----------------------------------------------------------------------------
// second_chance_frame_evictor_core
// Frame table with second-chance replacement, built as a row of order cells.
// ----------------------------------------------------------------------------
// Input words arrive on i_in_valid / o_in_stall, result words leave on
// o_out_valid / i_out_stall, one result word for each input word.
// frames_in_use is to be written through i_cfg_we / i_cfg_wdata only
// while idle; the block itself does not enforce this. One word is handled
// at a time. Mark words and allocations that find a free frame give their
// result from the execute state; a free that finds its frame also passes
// the remove state. An allocation that must evict scans the age order one
// cell per cycle from the oldest frame, in the scan state, until it finds
// a victim. A new word is taken only once the previous result word has
// been taken, so a stalled receiver holds the block. Reset empties the
// table, sets frames_in_use to 16 and drops any pending result.
// ----------------------------------------------------------------------------
module second_chance_frame_evictor_core
    import scfe_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [3:0]  i_frame_index,
    input  logic [7:0]  i_owner_id,
    input  logic [19:0] i_virtual_page,
    input  logic        i_swap_backed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_granted_frame,
    output logic        o_evicted,
    output logic [7:0]  o_victim_owner,
    output logic [19:0] o_victim_page,
    output logic        o_victim_needs_swap
);

    localparam int ID_W  = $clog2(FRAMES);
    localparam int CNT_W = $clog2(FRAMES + 1);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_REMOVE} t_state;

    t_state            r_state, n_state;
    logic [4:0]        r_cfg;
    logic [2:0]        r_mode;
    logic [3:0]        r_fi;
    t_slot             r_new;
    logic [FRAMES-1:0] r_used, n_used;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [ID_W-1:0]   r_pos, n_pos;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_status, n_status;
    logic [3:0]        r_granted, n_granted;
    logic              r_evicted, n_evicted;
    logic [7:0]        r_v_owner, n_v_owner;
    logic [19:0]       r_v_page, n_v_page;
    logic              r_v_swap, n_v_swap;

    t_cell_ctl         w_ctl;
    logic [ID_W-1:0]   w_new_id;
    logic              c_valid [FRAMES];
    logic [ID_W-1:0]   c_id    [FRAMES];
    t_slot             c_slot  [FRAMES];

    logic [31:0]       w_lim;
    logic              w_free_found;
    logic [ID_W-1:0]   w_free_id;
    logic              w_any_unpinned;
    logic [ID_W-1:0]   w_loc_pos;
    logic [ID_W-1:0]   w_fid;
    logic              w_fi_ok;
    logic              w_accept;
    t_slot             w_sel;
    logic [ID_W-1:0]   w_pos_inc;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;

    assign w_lim = (r_cfg == 5'd0) ? 32'd1 :
                   ((32'(r_cfg) > FRAMES) ? 32'(FRAMES) : 32'(r_cfg));
    assign w_fid   = ID_W'(r_fi);
    assign w_fi_ok = (32'(r_fi) < FRAMES) && r_used[w_fid];
    assign w_sel   = c_slot[r_pos];
    assign w_pos_inc = (32'(r_pos) + 32'd1 >= 32'(r_live)) ? '0 : r_pos + 1'b1;

    always_comb begin
        w_free_found   = 1'b0;
        w_free_id      = '0;
        w_any_unpinned = 1'b0;
        w_loc_pos      = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (!r_used[i] && (32'(i) < w_lim)) begin
                w_free_found = 1'b1;
                w_free_id    = ID_W'(i);
            end
        end
        for (int i = 0; i < FRAMES; i++) begin
            if (c_valid[i] && !c_slot[i].pin) begin
                w_any_unpinned = 1'b1;
            end
            if (c_valid[i] && (c_id[i] == w_fid)) begin
                w_loc_pos = w_loc_pos | ID_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_live      = r_live;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_granted   = r_granted;
        n_evicted   = r_evicted;
        n_v_owner   = r_v_owner;
        n_v_page    = r_v_page;
        n_v_swap    = r_v_swap;
        w_ctl.cmd   = CMD_HOLD;
        w_ctl.mode  = r_mode;
        w_new_id    = w_free_id;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_granted   = r_fi;
                n_evicted   = 1'b0;
                n_v_owner   = '0;
                n_v_page    = '0;
                n_v_swap    = 1'b0;
                case (r_mode) inside
                    MODE_ALLOC: begin
                        n_granted = '0;
                        if (w_free_found) begin
                            w_ctl.cmd         = CMD_APPEND;
                            n_used[w_free_id] = 1'b1;
                            n_live            = r_live + 1'b1;
                            n_granted         = 4'(w_free_id);
                        end else if (!w_any_unpinned) begin
                            n_status = ST_ALL_PINNED;
                        end else begin
                            n_out_valid = 1'b0;
                            n_pos       = '0;
                            n_state     = S_SCAN;
                        end
                    end
                    MODE_FREE, MODE_ACCESS, MODE_DIRTY, MODE_PIN, MODE_UNPIN: begin
                        if (!w_fi_ok) begin
                            n_status = ST_NOT_ALLOC;
                        end else if (r_mode == MODE_FREE) begin
                            n_used[w_fid] = 1'b0;
                            n_live        = r_live - 1'b1;
                            n_pos         = w_loc_pos;
                            n_out_valid   = 1'b0;
                            n_state       = S_REMOVE;
                        end else begin
                            w_ctl.cmd = CMD_MARK;
                        end
                    end
                    default: n_status = ST_OK;
                endcase
            end
            S_REMOVE: begin
                w_ctl.cmd   = CMD_REMOVE;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                if (!w_sel.pin && w_sel.acc) begin
                    w_ctl.cmd = CMD_CLEAR_ACC;
                    n_pos     = w_pos_inc;
                end else if (!w_sel.pin) begin
                    w_ctl.cmd   = CMD_EVICT;
                    w_new_id    = c_id[r_pos];
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_granted   = 4'(c_id[r_pos]);
                    n_evicted   = 1'b1;
                    n_v_owner   = w_sel.owner;
                    n_v_page    = w_sel.vpage;
                    n_v_swap    = w_sel.dirty || w_sel.swap;
                    n_state     = S_IDLE;
                end else begin
                    n_pos = w_pos_inc;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= 5'd16;
            r_used      <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_evicted <= n_evicted;
        r_v_owner <= n_v_owner;
        r_v_page  <= n_v_page;
        r_v_swap  <= n_v_swap;
        if (w_accept) begin
            r_mode      <= i_mode;
            r_fi        <= i_frame_index;
            r_new.acc   <= 1'b0;
            r_new.dirty <= 1'b0;
            r_new.pin   <= 1'b0;
            r_new.swap  <= i_swap_backed;
            r_new.owner <= i_owner_id;
            r_new.vpage <= i_virtual_page;
        end
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        logic            w_prev_valid;
        logic            w_next_valid;
        logic [ID_W-1:0] w_next_id;
        t_slot           w_next_slot;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = c_valid[g-1];
        end
        if (g == FRAMES - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_id    = '0;
            assign w_next_slot  = '0;
        end else begin : g_link
            assign w_next_valid = c_valid[g+1];
            assign w_next_id    = c_id[g+1];
            assign w_next_slot  = c_slot[g+1];
        end

        scfe_cell #(.ID_W(ID_W)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_match_id   (w_fid),
            .i_new_id     (w_new_id),
            .i_new_slot   (r_new),
            .i_sel        (r_pos == ID_W'(g)),
            .i_after      (ID_W'(g) >= r_pos),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_id    (w_next_id),
            .i_next_slot  (w_next_slot),
            .o_valid      (c_valid[g]),
            .o_id         (c_id[g]),
            .o_slot       (c_slot[g])
        );
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_granted_frame     = r_granted;
    assign o_evicted           = r_evicted;
    assign o_victim_owner      = r_v_owner;
    assign o_victim_page       = r_v_page;
    assign o_victim_needs_swap = r_v_swap;

endmodule

// ===== src/scfe_checker.sv =====
// ----------------------------------------------------------------------------
// scfe_checker
// Port-level checks on the frame evictor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scfe_checker
    import scfe_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [4:0]  i_cfg_wdata,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [2:0]  i_mode,
    input logic [3:0]  i_frame_index,
    input logic [7:0]  i_owner_id,
    input logic [19:0] i_virtual_page,
    input logic        i_swap_backed,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_granted_frame,
    input logic        o_evicted,
    input logic [7:0]  o_victim_owner,
    input logic [19:0] o_victim_page,
    input logic        o_victim_needs_swap
);

    // A stalled result word stays put.
    `SCFE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_granted_frame) && $stable(o_victim_page))

    // No new word is taken while a result waits.
    `SCFE_ASSERT_IMP(a_one_word, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // An eviction is always a successful allocation.
    `SCFE_ASSERT_IMP(a_evict_ok, i_clk, i_rst_n, o_out_valid && o_evicted, o_status == ST_OK)

    // Without an eviction the victim fields read zero.
    `SCFE_ASSERT_IMP(a_no_victim, i_clk, i_rst_n, o_out_valid && !o_evicted, o_victim_owner == 8'd0 && o_victim_page == 20'd0 && !o_victim_needs_swap)

    // Reset drops any pending result.
    `SCFE_ASSERT_NXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind second_chance_frame_evictor_core scfe_checker u_scfe_checker (.*);

// ===== test/second_chance_frame_evictor_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// second_chance_frame_evictor_core_test
// Drives allocate, free, mark and pin words into the frame evictor under
// random idling on both channels. A scoreboard predicts each result word,
// including the second-chance eviction scan, and compares every field.
// ----------------------------------------------------------------------------
module second_chance_frame_evictor_core_test;
    import scfe_pkg::*;

    localparam int NFR = 16;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame;
        logic        evicted;
        logic [7:0]  owner;
        logic [19:0] vpage;
        logic        needs_swap;
    } t_res;

    class frame_table_scoreboard;
        bit          valid_q[NFR];
        logic [7:0]  owner_q[NFR];
        logic [19:0] vpage_q[NFR];
        bit          acc_q[NFR];
        bit          dirty_q[NFR];
        bit          pin_q[NFR];
        bit          swap_q[NFR];
        int          age_q[$];
        int          limit;
        t_res        pending[$];
        int          mismatches;

        function void clear();
            foreach (valid_q[i]) begin
                valid_q[i] = 0; acc_q[i] = 0; dirty_q[i] = 0; pin_q[i] = 0;
            end
            age_q.delete();
            limit = 16;
            mismatches = 0;
        endfunction

        function void set_limit(logic [4:0] v);
            limit = (v < 1) ? 1 : ((v > NFR) ? NFR : v);
        endfunction

        function void place(int f, logic [7:0] o, logic [19:0] p, bit s);
            valid_q[f] = 1; owner_q[f] = o; vpage_q[f] = p;
            acc_q[f] = 0; dirty_q[f] = 0; pin_q[f] = 0; swap_q[f] = s;
            age_q.push_back(f);
        endfunction

        function void drop_age(int f);
            foreach (age_q[i]) if (age_q[i] == f) begin
                age_q.delete(i);
                break;
            end
        endfunction

        function void note_word(logic [2:0] m, logic [3:0] fi, logic [7:0] o,
                                logic [19:0] p, bit s);
            t_res r;
            int f, pos, vic;
            bit any;
            r = '0;
            r.frame = fi;
            if (m == MODE_ALLOC) begin
                r.frame = '0;
                f = -1;
                for (int i = 0; i < limit; i++) if (!valid_q[i]) begin
                    f = i;
                    break;
                end
                if (f >= 0) begin
                    place(f, o, p, s);
                    r.frame = 4'(f);
                end else begin
                    any = 0;
                    foreach (age_q[i]) if (!pin_q[age_q[i]]) any = 1;
                    if (!any) r.status = ST_ALL_PINNED;
                    else begin
                        // Sweep from the oldest frame, giving accessed frames
                        // a second chance by clearing their bit.
                        pos = 0;
                        vic = 0;
                        for (int k = 0; k < 2 * age_q.size() + 1; k++) begin
                            f = age_q[pos];
                            if (!pin_q[f]) begin
                                if (acc_q[f]) acc_q[f] = 0;
                                else begin
                                    vic = f;
                                    break;
                                end
                            end
                            pos = (pos + 1 >= age_q.size()) ? 0 : pos + 1;
                        end
                        r.evicted = 1;
                        r.owner = owner_q[vic];
                        r.vpage = vpage_q[vic];
                        r.needs_swap = dirty_q[vic] | swap_q[vic];
                        drop_age(vic);
                        place(vic, o, p, s);
                        r.frame = 4'(vic);
                    end
                end
            end else if (m <= MODE_UNPIN) begin
                if (!valid_q[fi]) r.status = ST_NOT_ALLOC;
                else case (m)
                    MODE_FREE: begin
                        drop_age(fi);
                        valid_q[fi] = 0; acc_q[fi] = 0; dirty_q[fi] = 0;
                        pin_q[fi] = 0;
                    end
                    MODE_ACCESS: acc_q[fi] = 1;
                    MODE_DIRTY:  dirty_q[fi] = 1;
                    MODE_PIN:    pin_q[fi] = 1;
                    default:     pin_q[fi] = 0;
                endcase
            end
            pending.push_back(r);
        endfunction

        function void check_word(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [4:0]  cfg_wdata = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  mode = 0;
    logic [3:0]  frame_index = 0;
    logic [7:0]  owner_id = 0;
    logic [19:0] virtual_page = 0;
    logic        swap_backed = 0;
    logic        out_valid;
    logic        out_stall = 0;
    t_res        got;
    longint      cycles = 0;
    int          out_wait = 0;

    frame_table_scoreboard board;

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    second_chance_frame_evictor_core u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_frame_index(frame_index), .i_owner_id(owner_id),
        .i_virtual_page(virtual_page), .i_swap_backed(swap_backed),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(got.status), .o_granted_frame(got.frame),
        .o_evicted(got.evicted), .o_victim_owner(got.owner),
        .o_victim_page(got.vpage), .o_victim_needs_swap(got.needs_swap)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: each taken word draws how many cycles the next one waits.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_word(got);
            out_wait = $urandom_range(0, 4);
        end else if (out_valid && out_wait > 0) begin
            out_wait = out_wait - 1;
        end
        out_stall <= (out_wait != 0);
    end

    task automatic send_word(logic [2:0] m, logic [3:0] fi, logic [7:0] o,
                             logic [19:0] p, bit s);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        mode <= m; frame_index <= fi; owner_id <= o;
        virtual_page <= p; swap_backed <= s;
        do @(posedge clk); while (in_stall);
        board.note_word(m, fi, o, p, s);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(logic [4:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        board.set_limit(v);
    endtask

    task automatic random_word();
        int r;
        logic [2:0] m;
        r = $urandom_range(0, 99);
        if (r < 40) m = MODE_ALLOC;
        else if (r < 50) m = MODE_FREE;
        else if (r < 70) m = MODE_ACCESS;
        else if (r < 80) m = MODE_DIRTY;
        else if (r < 88) m = MODE_PIN;
        else if (r < 97) m = MODE_UNPIN;
        else m = 3'($urandom_range(6, 7));
        send_word(m, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  20'($urandom_range(0, 20'hFFFFF)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        board = new();
        board.clear();
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: invalid frame, fill, extremes, all pinned, unused modes.
        send_word(MODE_FREE, 4'd15, 0, 0, 0);
        write_limit(5'd2);
        send_word(MODE_ALLOC, 0, 8'hFF, 20'hFFFFF, 1);
        send_word(MODE_ALLOC, 0, 8'h00, 20'h00000, 0);
        send_word(MODE_ACCESS, 4'd0, 0, 0, 0);
        send_word(MODE_ALLOC, 0, 8'h5A, 20'hA5A5A, 0);
        send_word(MODE_DIRTY, 4'd0, 0, 0, 0);
        send_word(MODE_PIN, 4'd0, 0, 0, 0);
        send_word(MODE_PIN, 4'd1, 0, 0, 0);
        send_word(MODE_ALLOC, 0, 8'h11, 20'h12345, 0);
        send_word(MODE_UNPIN, 4'd0, 0, 0, 0);
        send_word(MODE_ALLOC, 0, 8'h22, 20'h54321, 1);
        send_word(3'd6, 4'd9, 8'hFF, 20'hFFFFF, 1);
        send_word(3'd7, 4'd15, 0, 0, 0);
        send_word(MODE_FREE, 4'd1, 0, 0, 0);
        send_word(MODE_UNPIN, 4'd1, 0, 0, 0);
        write_limit(5'd0);
        send_word(MODE_ALLOC, 0, 8'h33, 20'h00001, 0);
        write_limit(5'd31);
        send_word(MODE_ALLOC, 0, 8'h44, 20'h80000, 1);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_limit(5'd16);
                1: write_limit(5'd1);
                2: write_limit(5'd4);
                3: write_limit(5'd20);
                default: write_limit(5'($urandom_range(1, 16)));
            endcase
            for (int i = 0; i < 100; i++) random_word();
        end

        drain();
        if (board.mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
